>>> sv/lfu_pkg.sv
// ----------------------------------------------------------------------------
// LFU cache package
// Shared types, constants and controller/datapath interface structs for the
// fully associative LFU cache with oldest-stamp tie-break.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int LFU_ENTRIES    = 16;
    localparam int LFU_KEY_BITS   = 64;
    localparam int LFU_COUNT_BITS = 32;

    localparam int LFU_TAG_W   = 64;
    localparam int LFU_VALUE_W = 64;
    localparam int LFU_TIME_W  = 32;
    localparam int LFU_CAP_W   = 5;

    localparam logic [LFU_CAP_W-1:0]  LFU_CAP_RESET = 5'd10;
    localparam logic [LFU_TIME_W-1:0] LFU_TIME_MAX  = '1;

    localparam logic LFU_OP_GET = 1'b0;
    localparam logic LFU_OP_PUT = 1'b1;

    typedef struct packed {
        logic                   opcode;
        logic [LFU_TAG_W-1:0]   key_tag;
        logic [LFU_VALUE_W-1:0] write_value;
    } lfu_in_t;

    typedef struct packed {
        logic                   found;
        logic [LFU_VALUE_W-1:0] read_value;
    } lfu_out_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } lfu_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_busy;
    } lfu_sts_t;

endpackage

>>> sv/lfu_ram.sv
// ----------------------------------------------------------------------------
// LFU generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// LFU cache controller
// Sequences one transaction: accept, scan all slots, settle the last read,
// then commit the update and the result.
// ----------------------------------------------------------------------------
module lfu_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  lfu_pkg::lfu_sts_t sts,
    output lfu_pkg::lfu_cmd_t cmd
);

    import lfu_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_LAST   = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (!sts.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign cmd.start  = (state_reg == S_IDLE) && in_valid;
    assign cmd.scan   = (state_reg == S_SCAN);
    assign cmd.commit = (state_reg == S_COMMIT) && !sts.out_busy;

endmodule

>>> sv/lfu_datapath.sv
// ----------------------------------------------------------------------------
// LFU cache datapath
// Entry RAM, valid bits, scan trackers for hit, free slot and victim,
// time counter, capacity register and output register.
// ----------------------------------------------------------------------------
module lfu_datapath #(
    parameter int ENTRIES    = lfu_pkg::LFU_ENTRIES,
    parameter int KEY_BITS   = lfu_pkg::LFU_KEY_BITS,
    parameter int COUNT_BITS = lfu_pkg::LFU_COUNT_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lfu_pkg::lfu_in_t               in_data,
    output lfu_pkg::lfu_out_t              out_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    input  logic                           cfg_write_en,
    input  logic [lfu_pkg::LFU_CAP_W-1:0]  cfg_write_data,
    input  lfu_pkg::lfu_cmd_t              cmd,
    output lfu_pkg::lfu_sts_t              sts
);

    import lfu_pkg::*;

    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int STAMP_LO = 0;
    localparam int COUNT_LO = STAMP_LO + LFU_TIME_W;
    localparam int VALUE_LO = COUNT_LO + COUNT_BITS;
    localparam int KEY_LO   = VALUE_LO + LFU_VALUE_W;
    localparam int ROW_W    = KEY_LO + KEY_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    lfu_in_t                 item_reg,        item_next;
    lfu_out_t                out_reg,         out_next;
    logic                    out_valid_reg,   out_valid_next;
    logic [ENTRIES-1:0]      valid_reg,       valid_next;
    logic [CNT_W-1:0]        valid_count_reg, valid_count_next;
    logic [LFU_TIME_W-1:0]   time_reg,        time_next;
    logic [LFU_CAP_W-1:0]    cap_reg,         cap_next;
    logic [IDX_W-1:0]        scan_idx_reg,    scan_idx_next;
    logic                    rd_valid_reg,    rd_valid_next;
    logic [IDX_W-1:0]        rd_idx_reg,      rd_idx_next;
    logic                    hit_found_reg,   hit_found_next;
    logic [IDX_W-1:0]        hit_idx_reg,     hit_idx_next;
    logic [COUNT_BITS-1:0]   hit_count_reg,   hit_count_next;
    logic [LFU_VALUE_W-1:0]  hit_value_reg,   hit_value_next;
    logic                    free_found_reg,  free_found_next;
    logic [IDX_W-1:0]        free_idx_reg,    free_idx_next;
    logic                    vic_found_reg,   vic_found_next;
    logic [IDX_W-1:0]        vic_idx_reg,     vic_idx_next;
    logic [COUNT_BITS-1:0]   vic_count_reg,   vic_count_next;
    logic [LFU_TIME_W-1:0]   vic_stamp_reg,   vic_stamp_next;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [ROW_W-1:0]        ram_wdata;
    logic [ROW_W-1:0]        ram_rdata;

    logic [KEY_BITS-1:0]     rd_key;
    logic [LFU_VALUE_W-1:0]  rd_value;
    logic [COUNT_BITS-1:0]   rd_count;
    logic [LFU_TIME_W-1:0]   rd_stamp;
    logic                    rd_entry_valid;
    logic                    rd_better;

    logic [KEY_BITS-1:0]     item_key;
    logic [CNT_W-1:0]        cap_eff;
    logic                    evict_cond;
    logic [IDX_W-1:0]        fill_idx;
    logic [COUNT_BITS-1:0]   bumped_count;
    logic [LFU_TIME_W-1:0]   time_inc;

    lfu_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_key         = ram_rdata[KEY_LO +: KEY_BITS];
    assign rd_value       = ram_rdata[VALUE_LO +: LFU_VALUE_W];
    assign rd_count       = ram_rdata[COUNT_LO +: COUNT_BITS];
    assign rd_stamp       = ram_rdata[STAMP_LO +: LFU_TIME_W];
    assign rd_entry_valid = valid_reg[rd_idx_reg];
    assign item_key       = item_reg.key_tag[KEY_BITS-1:0];

    assign rd_better = !vic_found_reg || (rd_count < vic_count_reg) ||
                       ((rd_count == vic_count_reg) && (rd_stamp < vic_stamp_reg));

    always_comb
    begin
        priority if (cap_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (32'(cap_reg) > 32'(ENTRIES))
        begin
            cap_eff = CNT_W'(ENTRIES);
        end
        else
        begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    assign evict_cond = (valid_count_reg >= cap_eff);

    always_comb
    begin
        priority if (!evict_cond)
        begin
            fill_idx = free_idx_reg;
        end
        else if (free_found_reg && (free_idx_reg < vic_idx_reg))
        begin
            fill_idx = free_idx_reg;
        end
        else
        begin
            fill_idx = vic_idx_reg;
        end
    end

    assign bumped_count = (hit_count_reg == COUNT_MAX) ? hit_count_reg
                                                       : hit_count_reg + 1'b1;
    assign time_inc     = (time_reg == LFU_TIME_MAX) ? time_reg : time_reg + 1'b1;

    always_comb
    begin
        item_next        = item_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg;
        valid_next       = valid_reg;
        valid_count_next = valid_count_reg;
        time_next        = time_reg;
        cap_next         = cap_reg;
        scan_idx_next    = scan_idx_reg;
        rd_valid_next    = cmd.scan;
        rd_idx_next      = scan_idx_reg;
        hit_found_next   = hit_found_reg;
        hit_idx_next     = hit_idx_reg;
        hit_count_next   = hit_count_reg;
        hit_value_next   = hit_value_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        vic_found_next   = vic_found_reg;
        vic_idx_next     = vic_idx_reg;
        vic_count_next   = vic_count_reg;
        vic_stamp_next   = vic_stamp_reg;
        ram_we           = 1'b0;
        ram_waddr        = hit_idx_reg;
        ram_wdata        = {item_key, item_reg.write_value, bumped_count, time_inc};

        if (cfg_write_en)
        begin
            cap_next = cfg_write_data;
        end

        if (cmd.start)
        begin
            item_next       = in_data;
            scan_idx_next   = '0;
            hit_found_next  = 1'b0;
            free_found_next = 1'b0;
            vic_found_next  = 1'b0;
        end

        if (cmd.scan)
        begin
            scan_idx_next = scan_idx_reg + 1'b1;
        end

        if (rd_valid_reg)
        begin
            if (rd_entry_valid && (rd_key == item_key) && !hit_found_reg)
            begin
                hit_found_next = 1'b1;
                hit_idx_next   = rd_idx_reg;
                hit_count_next = rd_count;
                hit_value_next = rd_value;
            end
            if (!rd_entry_valid && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = rd_idx_reg;
            end
            if (rd_entry_valid && rd_better)
            begin
                vic_found_next = 1'b1;
                vic_idx_next   = rd_idx_reg;
                vic_count_next = rd_count;
                vic_stamp_next = rd_stamp;
            end
        end

        if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.commit)
        begin
            out_valid_next      = 1'b1;
            out_next.found      = hit_found_reg;
            out_next.read_value = '0;
            if (item_reg.opcode == LFU_OP_GET)
            begin
                if (hit_found_reg)
                begin
                    time_next           = time_inc;
                    ram_we              = 1'b1;
                    ram_wdata           = {item_key, hit_value_reg, bumped_count, time_inc};
                    out_next.read_value = hit_value_reg;
                end
            end
            else
            begin
                time_next = time_inc;
                ram_we    = 1'b1;
                if (!hit_found_reg)
                begin
                    ram_waddr = fill_idx;
                    ram_wdata = {item_key, item_reg.write_value,
                                 COUNT_BITS'(1), time_inc};
                    if (evict_cond)
                    begin
                        valid_next[vic_idx_reg] = 1'b0;
                    end
                    else
                    begin
                        valid_count_next = valid_count_reg + 1'b1;
                    end
                    valid_next[fill_idx] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            valid_reg       <= '0;
            valid_count_reg <= '0;
            time_reg        <= '0;
            cap_reg         <= LFU_CAP_RESET;
            scan_idx_reg    <= '0;
            rd_valid_reg    <= 1'b0;
            hit_found_reg   <= 1'b0;
            free_found_reg  <= 1'b0;
            vic_found_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg   <= out_valid_next;
            valid_reg       <= valid_next;
            valid_count_reg <= valid_count_next;
            time_reg        <= time_next;
            cap_reg         <= cap_next;
            scan_idx_reg    <= scan_idx_next;
            rd_valid_reg    <= rd_valid_next;
            hit_found_reg   <= hit_found_next;
            free_found_reg  <= free_found_next;
            vic_found_reg   <= vic_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        out_reg       <= out_next;
        rd_idx_reg    <= rd_idx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_count_reg <= hit_count_next;
        hit_value_reg <= hit_value_next;
        free_idx_reg  <= free_idx_next;
        vic_idx_reg   <= vic_idx_next;
        vic_count_reg <= vic_count_next;
        vic_stamp_reg <= vic_stamp_next;
    end

    assign out_data      = out_reg;
    assign out_valid     = out_valid_reg;
    assign sts.scan_last = (scan_idx_reg == IDX_W'(ENTRIES - 1));
    assign sts.out_busy  = out_valid_reg && out_stall;

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        32'(valid_count_reg) == $countones(valid_reg))
        else $error("valid count does not match the valid bits");

    a_evict_has_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (item_reg.opcode == LFU_OP_PUT) && !hit_found_reg && evict_cond)
        |-> vic_found_reg)
        else $error("eviction without a victim");

    a_fill_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (item_reg.opcode == LFU_OP_PUT) && !hit_found_reg)
        |=> valid_reg[$past(fill_idx)])
        else $error("filled slot is not valid");

    a_miss_keeps_time: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (item_reg.opcode == LFU_OP_GET) && !hit_found_reg)
        |=> $stable(time_reg) && $stable(valid_reg))
        else $error("get miss changed the cache state");

endmodule

>>> sv/lfu_cache_lru_tiebreak_top.sv
// ----------------------------------------------------------------------------
// LFU cache with oldest-stamp tie-break, top level
// Transactions are taken one at a time: in_stall is high from acceptance until the
// result is committed. The scan reads one slot per cycle from the single read port
// of the entry RAM; the commit waits while the output is stalled.
// Reset: all entries invalid, time counter zero, capacity 10; no clearing pass.
// ----------------------------------------------------------------------------
module lfu_cache_lru_tiebreak_top #(
    parameter int ENTRIES    = lfu_pkg::LFU_ENTRIES,
    parameter int KEY_BITS   = lfu_pkg::LFU_KEY_BITS,
    parameter int COUNT_BITS = lfu_pkg::LFU_COUNT_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  lfu_pkg::lfu_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output lfu_pkg::lfu_out_t             out_data,
    input  logic                          cfg_write_en,
    input  logic [lfu_pkg::LFU_CAP_W-1:0] cfg_write_data
);

    import lfu_pkg::*;

    lfu_cmd_t cmd;
    lfu_sts_t sts;

    lfu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    lfu_datapath #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_data        (in_data),
        .out_data       (out_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule
